/* sv/f2i_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package f2i_pkg;

    typedef enum logic [2:0] {
        FMT_INT32  = 3'd0,
        FMT_INT16  = 3'd1,
        FMT_UINT16 = 3'd2,
        FMT_UINT8  = 3'd3,
        FMT_INT8   = 3'd4,
        FMT_UINT32 = 3'd5
    } fmt_code_t;

    typedef struct packed {
        logic [31:0] float_bits;
        logic        last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [32:0] int_value;
        logic               last_out;
    } out_word_t;

    localparam logic [7:0] EXP_ONE_LSB = 8'd150;

endpackage
`default_nettype wire

/* sv/float_to_integer_saturating_convert.sv */
`timescale 1ns / 1ps
// Input accept to result valid passes through the input register, then the result register.
// Throughput: one word per cycle; both registers advance together when not stalled.
// Stall propagates combinationally from the output stage back to the input.
// Reset (rst_n low, async): both valid flags cleared, target format set to int32.
`default_nettype none
module float_to_integer_saturating_convert
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_wdata,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire f2i_pkg::in_word_t  in_data,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      f2i_pkg::out_word_t out_data
);
    import f2i_pkg::*;

    logic [2:0]  fmt_reg;
    in_word_t    in_reg;
    logic        in_vld_reg;
    out_word_t   out_reg;
    logic        out_vld_reg;
    logic        adv;
    logic        in_load;

    // Pipeline advances when the result slot is free or being taken
    assign adv      = !out_vld_reg || !out_stall;
    // Input stage loads when it is empty or moving on
    assign in_load  = adv || !in_vld_reg;
    assign in_stall = !in_load;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    // Format register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_INT32;
        else if (cfg_we)
            fmt_reg <= cfg_wdata;
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_vld_reg  <= in_valid;
            if (adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    // Round and saturate to int32
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] man;
    logic        is_nan;
    logic        huge;
    logic [39:0] shl;
    logic [4:0]  rsh;
    logic [24:0] rnd;
    logic [32:0] mag;
    logic signed [32:0] r32;
    logic signed [32:0] v_next;
    out_word_t   out_next;

    always_comb
    begin
        sgn    = in_reg.float_bits[31];
        ex     = in_reg.float_bits[30:23];
        man    = {1'b1, in_reg.float_bits[22:0]};
        is_nan = (ex == 8'hFF) && (in_reg.float_bits[22:0] != 23'd0);
        // magnitude of 2^31 or more saturates in either sign
        huge   = (ex == 8'hFF) || (ex > 8'd157);
        shl    = '0;
        rsh    = '0;
        rnd    = '0;
        mag    = '0;
        if (ex == 8'd0)
            mag = '0;
        else if (ex >= EXP_ONE_LSB)
        begin
            shl = {16'd0, man} << (ex - EXP_ONE_LSB);
            mag = shl[32:0];
        end
        else if ((EXP_ONE_LSB - ex) <= 8'd25)
        begin
            rsh = 5'(EXP_ONE_LSB - ex);
            rnd = ({1'b0, man} + (25'd1 << (rsh - 5'd1))) >> rsh;
            mag = {8'd0, rnd};
        end
        if (!sgn)
            r32 = (huge || mag > 33'h07FFFFFFF) ? 33'sh07FFFFFFF : $signed(mag);
        else
            r32 = (huge || mag > 33'h080000000) ? -33'sh080000000 : -$signed(mag);

        // Format step
        case (fmt_reg)
            FMT_INT32:  v_next = r32;
            FMT_INT16:  v_next = {{17{r32[15]}}, r32[15:0]};
            FMT_UINT16: v_next = r32[32] ? '0 : {17'd0, r32[15:0]};
            FMT_UINT8:  v_next = r32[32] ? '0 : (r32 > 33'sd255 ? 33'sd255 : r32);
            FMT_INT8:   v_next = (r32 < -33'sd127) ? -33'sd127 :
                                 (r32 > 33'sd127 ? 33'sd127 : r32);
            FMT_UINT32: v_next = r32[32] ? '0 : r32;
            default:    v_next = '0;
        endcase
        if (is_nan)
            v_next = '0;
        out_next.int_value = v_next;
        out_next.last_out  = in_reg.last_in;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_load)
            in_reg  <= in_data;
        if (adv)
            out_reg <= out_next;
    end

    // Result stage only loads from a valid input stage
    a_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !in_vld_reg) |=> !out_vld_reg) else $error("spurious result");
    // Held result stays when stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |=> out_vld_reg && $stable(out_reg))
        else $error("result lost");
    // Input stall only with a full pipe
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_vld_reg && in_vld_reg)) else $error("bad stall");

endmodule
`default_nettype wire
